// ===== src/shs_pkg.sv =====
// Shared types, constants and tables for the streaming SHA-256 hash block.
// Used by shs_ctrl, shs_dp and sha256_stream_hash; depends on nothing.
package shs_pkg;

  // Input beat: one optional message byte and an optional finish request.
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       finish;
  } in_t;

  // Output beat: the 256-bit digest as eight big-endian words.
  typedef struct packed {
    logic [31:0] digest_w0;
    logic [31:0] digest_w1;
    logic [31:0] digest_w2;
    logic [31:0] digest_w3;
    logic [31:0] digest_w4;
    logic [31:0] digest_w5;
    logic [31:0] digest_w6;
    logic [31:0] digest_w7;
  } out_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    SRC_MSG  = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_e;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       byte_shift;
    src_e       byte_src;
    logic       count_en;
    logic       v_load;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_add;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== src/shs_dp.sv =====
// Datapath of the streaming SHA-256 hash: block buffer and schedule window,
// round unit, chaining words, bit count and digest register. Uses shs_pkg.
module shs_dp import shs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] msg_byte_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output out_t       digest_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [31:0]  chain_q [8];
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  out_t         dig_q;

  logic [7:0]  byte_in;
  logic [2:0]  len_sel;
  logic [31:0] w0, w1, w9, w14, w_new, s0, s1;
  logic [31:0] e, a, big0, big1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Length bytes go out most significant first: fill 56 takes bits 63:56.
  assign len_sel = 3'd7 - fill_q[2:0];

  always_comb begin
    case (cmd_i.byte_src)
      SRC_MSG:  byte_in = msg_byte_i;
      SRC_MARK: byte_in = PAD_MARK;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = bits_q[{len_sel, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  // Schedule window: word 0 sits in the top bits of the buffer.
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign e    = v_q[4];
  assign a    = v_q[0];
  assign big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign ch   = (e & v_q[5]) ^ (~e & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + K_TABLE[cmd_i.round_idx] + w0;
  assign big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.byte_shift) begin
      blk_d = {blk_q[503:0], byte_in};
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  always_comb begin
    v_d = v_q;
    if (cmd_i.v_load) begin
      v_d = chain_q;
    end else if (cmd_i.round_en) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
    if (cmd_i.out_load) begin
      dig_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IV_TABLE;
      fill_q  <= '0;
      bits_q  <= '0;
    end else if (cmd_i.out_load) begin
      chain_q <= IV_TABLE;
      fill_q  <= '0;
      bits_q  <= '0;
    end else begin
      if (cmd_i.chain_add) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
      end
      if (cmd_i.byte_shift) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.count_en) begin
        bits_q <= bits_q + BITS_PER_BYTE;
      end
    end
  end

  assign sts_o.fill = fill_q;
  assign digest_o   = dig_q;

endmodule

// ===== src/shs_ctrl.sv =====
// Controller of the streaming SHA-256 hash: sequences byte loading, padding,
// the 64 rounds, the chaining add and the digest handoff. Uses shs_pkg.
module shs_ctrl import shs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic has_byte_i,
  input  logic finish_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MARK  = 7'b0000010,
    ST_ZERO  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic       fin_pend_q, fin_pend_d;
  logic       pad_q, pad_d;
  logic       final_q, final_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    fin_pend_d = fin_pend_q;
    pad_d      = pad_q;
    final_d    = final_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.byte_src  = SRC_ZERO;
    cmd_o.round_idx = rnd_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.byte_shift = 1'b1;
            cmd_o.byte_src   = SRC_MSG;
            cmd_o.count_en   = 1'b1;
            if (sts_i.fill == FILL_LAST) begin
              cmd_o.v_load = 1'b1;
              fin_pend_d   = finish_i;
              rnd_d        = '0;
              state_d      = ST_ROUND;
            end else if (finish_i) begin
              state_d = ST_MARK;
            end
          end else if (finish_i) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd_o.byte_shift = 1'b1;
        cmd_o.byte_src   = SRC_MARK;
        pad_d            = 1'b1;
        if (sts_i.fill == FILL_LAST) begin
          cmd_o.v_load = 1'b1;
          rnd_d        = '0;
          state_d      = ST_ROUND;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (sts_i.fill == LEN_START) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.byte_shift = 1'b1;
          cmd_o.byte_src   = SRC_ZERO;
          if (sts_i.fill == FILL_LAST) begin
            cmd_o.v_load = 1'b1;
            rnd_d        = '0;
            state_d      = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        cmd_o.byte_shift = 1'b1;
        cmd_o.byte_src   = SRC_LEN;
        if (sts_i.fill == FILL_LAST) begin
          cmd_o.v_load = 1'b1;
          final_d      = 1'b1;
          rnd_d        = '0;
          state_d      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.chain_add = 1'b1;
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_ZERO;
        end else if (fin_pend_q) begin
          fin_pend_d = 1'b0;
          state_d    = ST_MARK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        // Hold the digest until the output register is free.
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          final_d        = 1'b0;
          pad_d          = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      fin_pend_q  <= 1'b0;
      pad_q       <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      fin_pend_q  <= fin_pend_d;
      pad_q       <= pad_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/sha256_stream_hash.sv =====
// Top level of the streaming SHA-256 hash block.
// Joins shs_ctrl and shs_dp; uses the beat types of shs_pkg.

// Streaming SHA-256 over a byte stream. Each input beat may carry one message
// byte (has_byte) and may ask to finish the message (finish); with both set,
// the byte is part of the digest. Every 64th byte starts a compression that
// runs one round per cycle through a single shared round unit: 64 rounds,
// then the chaining add; the input is not ready during each compression.
// A finish beat pads the message byte by byte through the same buffer
// shift path (pad mark, zero fill, eight big-endian length bytes), then
// runs one compression, or two when 56 or more bytes were already buffered;
// the digest is held back while an earlier digest still waits in the output
// register. The digest lands in an output register as eight big-endian
// words, after which the block restarts from the initial hash values and
// accepts the next message while the digest beat still waits to be taken.
// There are no configuration registers and no clearing pass after reset.
module sha256_stream_hash import shs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence loading, padding and rounds; own the output valid flag.
  shs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .has_byte_i  (in_data_i.has_byte),
    .finish_i    (in_data_i.finish),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the block, the chaining words, the bit count and the digest.
  shs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .msg_byte_i (in_data_i.msg_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .digest_o   (out_data_o)
  );

endmodule

// ===== verif/sha256_digest_checker.sv =====
// Digest checker for sha256_stream_hash: watches both channels, keeps its own
// SHA-256 state and compares every digest beat. Depends on shs_pkg beat types.
module sha256_digest_checker import shs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_h [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] nbits;
  out_t        expected_digests [$];
  int unsigned fails;
  int unsigned digests_seen;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++) begin
      v[i] = hash_h[i];
    end
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      hash_h[i] = hash_h[i] + v[i];
    end
  endtask

  task automatic restart_message();
    int i;
    for (i = 0; i < 8; i++) begin
      hash_h[i] = START_H[i];
    end
    for (i = 0; i < 64; i++) begin
      blk[i] = 8'h00;
    end
    fill  = 6'd0;
    nbits = 64'd0;
  endtask

  // Append the byte, then pad, add the length and queue the digest on finish.
  task automatic absorb_beat(input in_t b);
    int unsigned idx;
    int i;
    if (b.has_byte) begin
      blk[fill] = b.msg_byte;
      nbits = nbits + 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress_block();
    end
    if (b.finish) begin
      idx = fill;
      blk[idx] = 8'h80;
      idx++;
      if (idx > 56) begin
        while (idx < 64) begin
          blk[idx] = 8'h00;
          idx++;
        end
        compress_block();
        idx = 0;
      end
      while (idx < 56) begin
        blk[idx] = 8'h00;
        idx++;
      end
      for (i = 0; i < 8; i++) begin
        blk[56 + i] = nbits[63 - 8*i -: 8];
      end
      compress_block();
      expected_digests.push_back({hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                  hash_h[4], hash_h[5], hash_h[6], hash_h[7]});
      restart_message();
    end
  endtask

  task automatic check_digest(input out_t got);
    out_t         want;
    logic [255:0] want_flat;
    logic [255:0] got_flat;
    int           i;
    if (expected_digests.size() == 0) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("digest beat %0d with nothing expected: %h", digests_seen, got);
    end else begin
      want      = expected_digests.pop_front();
      want_flat = want;
      got_flat  = got;
      for (i = 0; i < 8; i++) begin
        if (got_flat[255 - 32*i -: 32] !== want_flat[255 - 32*i -: 32]) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("digest beat %0d word %0d: expected %h, got %h", digests_seen, i,
                     want_flat[255 - 32*i -: 32], got_flat[255 - 32*i -: 32]);
        end
      end
    end
    digests_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      expected_digests.delete();
      fails        = 0;
      digests_seen = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_digest(out_data_i);
      if (in_valid_i && in_ready_i) absorb_beat(in_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_digests.size();
  end

endmodule

// ===== verif/tb_sha256_stream_hash.sv =====
// Top of the sha256_stream_hash testbench: clock, reset, byte stream stimulus,
// digest receiver, stall watchdog and verdict. Uses shs_pkg and the checker.
module tb_sha256_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  localparam int unsigned IDLE_PCT      = 18;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  // A digest waits for padding and compression after finish; the long receiver
  // hold-off adds its own length on top, so leave a wide margin.
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES  = 250;
  localparam int unsigned HOLD_START    = 800;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned RX_FLAT_START = 2500;
  localparam int unsigned RX_FLAT_END   = 4000;
  localparam int unsigned TX_FLAT_START = 300;
  localparam int unsigned TX_FLAT_END   = 500;

  // Message lengths around the block edges: pad fits, pad spills into a
  // second block, exact block multiples.
  localparam int unsigned EDGE_LENS [11] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned pending_digests;
  int unsigned stall_cycles;
  int unsigned items_sent;

  sha256_stream_hash u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  sha256_digest_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_digests)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_t mk_beat(input logic [7:0] data, input logic has, input logic fin);
    in_t b;
    b.msg_byte = data;
    b.has_byte = has;
    b.finish   = fin;
    return b;
  endfunction

  // Offer one beat and hold it until the block takes it. Drop valid only when
  // a gap comes before this beat, so back-to-back beats keep valid high.
  task automatic send_beat(input in_t b);
    int unsigned gap;
    gap = 0;
    if (!(items_sent >= TX_FLAT_START && items_sent < TX_FLAT_END)) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.has_byte || b.finish) items_sent++;
  endtask

  // Receiver: random backpressure, one long hold-off so the block fills up
  // and stalls its input, then a stretch that takes every digest at once.
  initial begin
    int unsigned cyc;
    out_ready = 1'b0;
    cyc = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;
      else if (cyc >= RX_FLAT_START && cyc < RX_FLAT_END)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      cyc++;
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned k;
    bit          fin_with_byte;
    in_valid     = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    items_sent   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored beat with a junk byte, empty message, one-byte
    // message with byte and finish together, bare finish after bytes 00 and
    // 80, an ignored beat in the middle of a message, and one more empty message.
    send_beat(mk_beat(8'ha5, 1'b0, 1'b0));
    send_beat(mk_beat(8'hff, 1'b0, 1'b1));
    send_beat(mk_beat(8'hff, 1'b1, 1'b1));
    send_beat(mk_beat(8'h00, 1'b1, 1'b0));
    send_beat(mk_beat(8'h80, 1'b1, 1'b0));
    send_beat(mk_beat(8'h5a, 1'b0, 1'b1));
    send_beat(mk_beat(8'h7f, 1'b1, 1'b0));
    send_beat(mk_beat(8'hff, 1'b0, 1'b0));
    send_beat(mk_beat(8'h01, 1'b1, 1'b1));
    send_beat(mk_beat(8'h00, 1'b0, 1'b1));

    // Random messages: mostly short, some at block edges, some multi-block.
    // Finish rides on the last byte or comes as a beat of its own, and a few
    // ignored beats are mixed in as noise.
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 12);
        4:          len = EDGE_LENS[$urandom_range(0, 10)];
        5:          len = $urandom_range(13, 70);
        6:          len = $urandom_range(100, 130);
        default:    len = $urandom_range(0, 4);
      endcase
      fin_with_byte = ($urandom_range(0, 1) == 1) && (len != 0);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b1,
                          fin_with_byte && (k == len - 1)));
      end
      if (!fin_with_byte)
        send_beat(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Wait out every queued digest, then give the block time to show any
    // stray beat before the verdict.
    while (pending_digests != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sha256_stream_hash.f =====
src/shs_pkg.sv
src/shs_dp.sv
src/shs_ctrl.sv
src/sha256_stream_hash.sv
verif/sha256_digest_checker.sv
verif/tb_sha256_stream_hash.sv
